// ===== rtl/core/read_priority_request_reorder_defines.svh =====
// Assertion macros for the read priority request reorder block
`ifndef READ_PRIORITY_REQUEST_REORDER_DEFINES_SVH
`define READ_PRIORITY_REQUEST_REORDER_DEFINES_SVH
`ifndef SYNTHESIS
`define RPRR_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RPRR_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPRR_CHECK(lbl, prop, msg)
`define RPRR_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/rprr_pkg.sv =====
// Types, constants and helpers of the read priority request reorder block
package rprr_pkg;
	localparam int TABLE_DEPTH = 32;
	localparam int EMIT_LIMIT = 32;
	localparam int LIM_I = (TABLE_DEPTH < EMIT_LIMIT) ? TABLE_DEPTH : EMIT_LIMIT;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [5:0] CNT_LIM = 6'(LIM_I);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SCHED = 1'b1;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	typedef struct packed {
		logic        op;
		logic [4:0]  slot;
		logic [5:0]  entry_count;
		logic [1:0]  req_kind;
		logic [31:0] start_addr;
		logic [31:0] span;
		logic [31:0] req_tag;
		logic [63:0] issue_stamp;
	} req_t;

	typedef struct packed {
		logic        has_entry;
		logic [4:0]  out_slot;
		logic [1:0]  out_kind;
		logic [31:0] out_addr;
		logic [31:0] out_span;
		logic [31:0] out_tag;
		logic [63:0] out_stamp;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [31:0] span;
		logic [31:0] tag;
		logic [63:0] stamp;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZERO,
		ST_P1_RD,
		ST_P1_CHK,
		ST_SC_RD,
		ST_SC_CHK,
		ST_P2_RD,
		ST_P2_CHK,
		ST_EM_RD,
		ST_EM_WR
	} state_t;

	// a starts at or below b and its wrapped end lies above b
	function automatic logic covers(ent_t a, ent_t b);
		logic [31:0] e;
		e = a.addr + a.span;
		return (a.addr <= b.addr) && (e > b.addr);
	endfunction
endpackage

// ===== rtl/core/rprr_req_if.sv =====
// Request channel interface
interface rprr_req_if import rprr_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/rprr_rsp_if.sv =====
// Result channel interface
interface rprr_rsp_if import rprr_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/rprr_ram.sv =====
// Generic single write, single read RAM with registered read
module rprr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/core/read_priority_request_reorder.sv =====
// Read priority request reorder: slot table, two pass scheduler, emitter
//
//  channel | dir | word                         | accepted when
//  req     | in  | load or schedule command     | req.valid && req.ready
//  rsp     | out | one scheduled entry per word | rsp.valid && rsp.ready
//
// A load is written to the input table as it is accepted. A schedule reads each
// slot in each pass, scans the slots for each write met in the first pass until
// an overlap or the last slot, then reads and emits one word per slot, using the
// single read port of each table RAM. A zero count gives one word, marked last.
// Reset clears per-entry valid bits of both tables; no clearing pass.
// req is taken only when idle; a pending output word stalls only the emitter.
module read_priority_request_reorder import rprr_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	rprr_req_if.sink    req,
	rprr_rsp_if.source  rsp
);
	`include "read_priority_request_reorder_defines.svh"

	state_t st_q, st_d;

	logic [IDX_W-1:0]       i_q, k_q, cnt_m1_q;
	logic [CNT_W-1:0]       fill_q;
	logic [TABLE_DEPTH-1:0] taken_q, in_vld_q, ord_vld_q;
	logic                   in_rv_s1, ord_rv_s1;
	ent_t                   cur_q;
	rsp_t                   out_q;
	logic                   out_v_q;

	logic             acc, out_free, i_last, k_last, ovl, place, out_load, adv_i;
	logic             in_we, in_re, ord_re;
	logic [IDX_W-1:0] in_raddr;
	logic [5:0]       sat;
	logic [ENT_W-1:0] in_rdata, ord_rdata;
	ent_t             rd_ent, ord_ent, place_ent;
	rsp_t             out_word;

	assign acc      = req.valid && req.ready;
	assign out_free = !out_v_q || rsp.ready;
	assign i_last   = (i_q == cnt_m1_q);
	assign k_last   = (k_q == cnt_m1_q);
	assign sat      = (req.data.entry_count > CNT_LIM) ? CNT_LIM : req.data.entry_count;
	assign in_we    = acc && (req.data.op == OP_LOAD) && (32'(req.data.slot) < TABLE_DEPTH);

	assign rd_ent  = in_rv_s1 ? ent_t'(in_rdata) : '0;
	assign ord_ent = ord_rv_s1 ? ent_t'(ord_rdata) : '0;
	// during a scan rd_ent is the other slot, cur_q the slot under test
	assign ovl = (k_q != i_q) && (covers(rd_ent, cur_q) || covers(cur_q, rd_ent));

	rprr_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (IDX_W'(req.data.slot)),
		.wdata (ENT_W'({req.data.req_kind, req.data.start_addr, req.data.span,
			req.data.req_tag, req.data.issue_stamp})),
		.re    (in_re),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	rprr_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ord_ram (
		.clk   (clk),
		.we    (place),
		.waddr (fill_q[IDX_W-1:0]),
		.wdata (ENT_W'(place_ent)),
		.re    (ord_re),
		.raddr (i_q),
		.rdata (ord_rdata)
	);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (acc && req.data.op == OP_SCHED) begin
					st_d = (sat == 6'd0) ? ST_ZERO : ST_P1_RD;
				end
			end
			ST_ZERO: if (out_free) st_d = ST_IDLE;
			ST_P1_RD: st_d = ST_P1_CHK;
			ST_P1_CHK: begin
				if (rd_ent.kind == KIND_WRITE) st_d = ST_SC_RD;
				else st_d = i_last ? ST_P2_RD : ST_P1_RD;
			end
			ST_SC_RD: st_d = ST_SC_CHK;
			ST_SC_CHK: begin
				if (ovl || k_last) st_d = i_last ? ST_P2_RD : ST_P1_RD;
				else st_d = ST_SC_RD;
			end
			ST_P2_RD: st_d = ST_P2_CHK;
			ST_P2_CHK: st_d = i_last ? ST_EM_RD : ST_P2_RD;
			ST_EM_RD: st_d = ST_EM_WR;
			ST_EM_WR: if (out_free) st_d = i_last ? ST_IDLE : ST_EM_RD;
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_re     = 1'b0;
		in_raddr  = i_q;
		ord_re    = 1'b0;
		place     = 1'b0;
		place_ent = rd_ent;
		out_load  = 1'b0;
		out_word  = '0;
		adv_i     = 1'b0;
		req.ready = 1'b0;
		case (st_q)
			ST_IDLE: req.ready = 1'b1;
			ST_ZERO: begin
				out_load      = out_free;
				out_word.last = 1'b1;
			end
			ST_P1_RD, ST_P2_RD: in_re = 1'b1;
			ST_SC_RD: begin
				in_re    = 1'b1;
				in_raddr = k_q;
			end
			ST_P1_CHK: begin
				place = (rd_ent.kind == KIND_READ);
				adv_i = (rd_ent.kind != KIND_WRITE);
			end
			ST_SC_CHK: begin
				place     = ovl && (k_q > i_q) && (rd_ent.kind == KIND_READ);
				place_ent = cur_q;
				adv_i     = ovl || k_last;
			end
			ST_P2_CHK: begin
				place = (rd_ent.kind == KIND_WRITE) && !taken_q[i_q];
				adv_i = 1'b1;
			end
			ST_EM_RD: ord_re = 1'b1;
			ST_EM_WR: begin
				out_load           = out_free;
				adv_i              = out_free;
				out_word.has_entry = 1'b1;
				out_word.out_slot  = 5'(i_q);
				out_word.out_kind  = ord_ent.kind;
				out_word.out_addr  = ord_ent.addr;
				out_word.out_span  = ord_ent.span;
				out_word.out_tag   = ord_ent.tag;
				out_word.out_stamp = ord_ent.stamp;
				out_word.last      = i_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			i_q       <= '0;
			k_q       <= '0;
			cnt_m1_q  <= '0;
			fill_q    <= '0;
			taken_q   <= '0;
			in_vld_q  <= '0;
			ord_vld_q <= '0;
			in_rv_s1  <= 1'b0;
			ord_rv_s1 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			st_q <= st_d;
			if (in_we) begin
				in_vld_q[IDX_W'(req.data.slot)] <= 1'b1;
			end
			if (acc && req.data.op == OP_SCHED) begin
				cnt_m1_q <= IDX_W'(sat - 6'd1);
				i_q      <= '0;
				fill_q   <= '0;
				taken_q  <= '0;
			end
			if (in_re) begin
				in_rv_s1 <= in_vld_q[in_raddr];
			end
			if (ord_re) begin
				ord_rv_s1 <= ord_vld_q[i_q];
			end
			if (st_q == ST_P1_CHK) begin
				k_q <= '0;
			end else if (st_q == ST_SC_CHK && !ovl && !k_last) begin
				k_q <= k_q + 1'b1;
			end
			if (place) begin
				ord_vld_q[fill_q[IDX_W-1:0]] <= 1'b1;
				taken_q[i_q]                 <= 1'b1;
				fill_q                       <= fill_q + 1'b1;
			end
			if (adv_i) begin
				i_q <= i_last ? '0 : i_q + 1'b1;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_P1_CHK || st_q == ST_P2_CHK) begin
			cur_q <= rd_ent;
		end
		if (out_load) begin
			out_q <= out_word;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// first pass only: the second pass starts with the first pass placements counted
	`RPRR_CHECK(a_fill_behind_scan, (st_q == ST_P1_CHK || st_q == ST_SC_CHK) |-> (fill_q <= CNT_W'(i_q)), "fill ran ahead of slot index")
	`RPRR_CHECK(a_taken_matches_fill, (st_q == ST_EM_RD) |-> ($countones(taken_q) == int'(fill_q)), "taken flags disagree with fill count")
	`RPRR_CHECK(a_last_word_marked, (st_q == ST_EM_WR && out_load && i_last) |=> (rsp.valid && rsp.data.last), "final word lacks last mark")
	`RPRR_CHECK(a_idle_after_last, (st_q == ST_EM_WR && out_load && i_last) |=> (st_q == ST_IDLE), "emitter did not return to idle")
endmodule
